### src/ald_score_vector_core_defines.svh
// assertion macros for the asymmetric laplace score core
`ifndef ALD_SCORE_VECTOR_CORE_DEFINES_SVH
`define ALD_SCORE_VECTOR_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ASV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/asv_pkg.sv
// shared constants and types for the asymmetric laplace score core
`timescale 1ns / 1ps
`default_nettype none

package asv_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int SQRT2_FRAC = 30;
    localparam logic [30:0] SQRT2_Q30 = 31'd1518500250;

    // divider geometry
    localparam int DIV_QW  = 36;
    localparam int DIV_NW  = 94;
    localparam int DIV_DW  = 93;
    localparam int DIV_LAT = DIV_QW + 1;

    // numerator and denominator alignment shifts
    localparam int SH_T1    = 3 * FRAC_BITS + 1 - SQRT2_FRAC;
    localparam int SH_DEN   = SQRT2_FRAC - FRAC_BITS - 1;
    localparam int SH_RECIP = 2 * FRAC_BITS + 1;
    localparam int SH_T7    = 2 * FRAC_BITS + 2;

    typedef struct packed {
        logic vld;
        logic neg;
        logic inv;
    } ctl_t;

endpackage

`default_nettype wire

### src/asv_div.sv
// pipelined restoring divider, one quotient bit per stage, saturating quotient
`timescale 1ns / 1ps
`default_nettype none

module asv_div
(
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [asv_pkg::DIV_NW-1:0]  num,
    input  wire logic [asv_pkg::DIV_DW-1:0]  den,
    output logic      [asv_pkg::DIV_QW-1:0]  quo
);

    localparam int QW = asv_pkg::DIV_QW;
    localparam int NW = asv_pkg::DIV_NW;
    localparam int DW = asv_pkg::DIV_DW;

    logic [DW-1:0] rem_reg [0:QW-1];
    logic [DW-1:0] den_reg [0:QW-1];
    logic [QW-1:0] low_reg [0:QW-1];
    logic [QW-1:0] quo_reg [1:QW];
    logic          ovf_reg [0:QW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DW'(num[NW-1:QW]);
            low_reg[0] <= num[QW-1:0];
            den_reg[0] <= den;
            ovf_reg[0] <= (DW'(num[NW-1:QW]) >= den);
        end
    end

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic [DW:0] trial;
        logic        ge;

        assign trial = {rem_reg[i], low_reg[i][QW-1-i]};
        assign ge    = (trial >= {1'b0, den_reg[i]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ovf_reg[i+1] <= ovf_reg[i];
            end
        end

        if (i == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    quo_reg[i+1] <= QW'(ge);
                end
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    quo_reg[i+1] <= {quo_reg[i][QW-2:0], ge};
                end
            end
        end

        if (i < QW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i+1] <= ge ? DW'(trial - {1'b0, den_reg[i]}) : trial[DW-1:0];
                    den_reg[i+1] <= den_reg[i];
                    low_reg[i+1] <= low_reg[i];
                end
            end
        end
    end

    assign quo = ovf_reg[QW] ? '1 : quo_reg[QW];

endmodule

`default_nettype wire

### src/ald_score_vector_core.sv
// throughput: one word per cycle while the output is not stalled
// three multiply and assemble stages, 37 divider stages, one output stage
// the six dividers (one quotient bit per stage) set the depth
// a stalled output holds the whole pipeline, nothing is dropped or repeated
// reset (rst_n low, asynchronous) clears every valid bit, payload is not reset
`timescale 1ns / 1ps
`default_nettype none

module ald_score_vector_core
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // observation, location, scale, skew, zero pad
    input  wire logic [127:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // score_location, score_scale, score_skew
    output logic [95:0]       m_axis_tdata,
    // saturated, invalid
    output logic [1:0]        m_axis_tuser
);

    `include "ald_score_vector_core_defines.svh"

    localparam int NW  = asv_pkg::DIV_NW;
    localparam int DW  = asv_pkg::DIV_DW;
    localparam int QW  = asv_pkg::DIV_QW;
    localparam int LAT = asv_pkg::DIV_LAT;

    function automatic logic [QW-1:0] round_term(input logic [QW-1:0] q);
        return QW'(q >> 1) + QW'(q[0]);
    endfunction

    function automatic logic [32:0] clamp32(input logic signed [38:0] v);
        logic [32:0] r;
        if (v > 39'sd2147483647)
        begin
            r = {1'b1, 32'h7FFF_FFFF};
        end
        else if (v < -39'sd2147483648)
        begin
            r = {1'b1, 32'h8000_0000};
        end
        else
        begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

    logic en;

    // input fields
    logic signed [31:0] obs;
    logic signed [31:0] loc_in;
    logic        [30:0] s_in;
    logic        [30:0] k_in;
    logic signed [32:0] dlt;
    logic        [32:0] dlt_abs;
    asv_pkg::ctl_t      ctl_in;

    assign obs     = s_axis_tdata[31:0];
    assign loc_in  = s_axis_tdata[63:32];
    assign s_in    = s_axis_tdata[94:64];
    assign k_in    = s_axis_tdata[125:95];
    assign dlt     = 33'(obs) - 33'(loc_in);
    assign dlt_abs = dlt[32] ? -dlt : dlt;

    assign ctl_in.vld = s_axis_tvalid;
    assign ctl_in.neg = dlt[32];
    assign ctl_in.inv = (s_in == '0) || (k_in == '0);

    // stage 1: square and cross products
    asv_pkg::ctl_t ctl1_reg;
    logic [31:0] a1_reg;
    logic [30:0] s1_reg, k1_reg;
    logic [61:0] ss1_reg, sk1_reg, kk1_reg, ck1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg  <= dlt_abs[31:0];
            s1_reg  <= s_in;
            k1_reg  <= k_in;
            ss1_reg <= 62'(s_in) * 62'(s_in);
            sk1_reg <= 62'(s_in) * 62'(k_in);
            kk1_reg <= 62'(k_in) * 62'(k_in);
            ck1_reg <= 62'(asv_pkg::SQRT2_Q30) * 62'(k_in);
        end
    end

    // stage 2: partial products of the triple products
    asv_pkg::ctl_t ctl2_reg;
    logic [30:0] s2_reg, k2_reg;
    logic [61:0] ss2_reg, sk2_reg, kk2_reg, ck2_reg;
    logic [62:0] ca2_reg;
    logic [61:0] ssk_lo2_reg, ssk_hi2_reg, skk_lo2_reg, skk_hi2_reg;
    logic [62:0] cka_lo2_reg, cka_hi2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg      <= s1_reg;
            k2_reg      <= k1_reg;
            ss2_reg     <= ss1_reg;
            sk2_reg     <= sk1_reg;
            kk2_reg     <= kk1_reg;
            ck2_reg     <= ck1_reg;
            ca2_reg     <= 63'(asv_pkg::SQRT2_Q30) * 63'(a1_reg);
            ssk_lo2_reg <= 62'(ss1_reg[30:0]) * 62'(k1_reg);
            ssk_hi2_reg <= 62'(ss1_reg[61:31]) * 62'(k1_reg);
            skk_lo2_reg <= 62'(sk1_reg[30:0]) * 62'(k1_reg);
            skk_hi2_reg <= 62'(sk1_reg[61:31]) * 62'(k1_reg);
            cka_lo2_reg <= 63'(ck1_reg[30:0]) * 63'(a1_reg);
            cka_hi2_reg <= 63'(ck1_reg[61:31]) * 63'(a1_reg);
        end
    end

    // stage 3: assemble numerators and denominators
    logic [92:0] ssk, skk;
    logic [93:0] cka;

    assign ssk = {ssk_hi2_reg, 31'b0} + 93'(ssk_lo2_reg);
    assign skk = {skk_hi2_reg, 31'b0} + 93'(skk_lo2_reg);
    assign cka = {cka_hi2_reg, 31'b0} + 94'(cka_lo2_reg);

    asv_pkg::ctl_t ctl3_reg;
    logic [NW-1:0] n_loc_reg, n_scl_reg, n_skw_reg, n_t7_reg;
    logic [DW-1:0] d_loc_reg, d_scl_reg, d_skw_reg, d_t3_reg, d_t6_reg, d_t7_reg;
    logic [NW-1:0] n_recip;

    assign n_recip = NW'(1) << asv_pkg::SH_RECIP;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (ctl2_reg.neg)
            begin
                n_loc_reg <= NW'(asv_pkg::SQRT2_Q30) << asv_pkg::SH_T1;
                d_loc_reg <= DW'(sk2_reg);
                n_scl_reg <= NW'(ca2_reg) << asv_pkg::SH_T1;
                d_scl_reg <= ssk;
                n_skw_reg <= NW'(ca2_reg) << asv_pkg::SH_T1;
                d_skw_reg <= skk;
            end
            else
            begin
                n_loc_reg <= NW'(ck2_reg);
                d_loc_reg <= DW'(s2_reg) << asv_pkg::SH_DEN;
                n_scl_reg <= cka;
                d_scl_reg <= DW'(ss2_reg) << asv_pkg::SH_DEN;
                n_skw_reg <= NW'(ca2_reg);
                d_skw_reg <= DW'(s2_reg) << asv_pkg::SH_DEN;
            end
            d_t3_reg <= DW'(s2_reg);
            d_t6_reg <= DW'(k2_reg);
            n_t7_reg <= NW'(k2_reg) << asv_pkg::SH_T7;
            d_t7_reg <= (DW'(1) << (2 * asv_pkg::FRAC_BITS)) + DW'(kk2_reg);
        end
    end

    // control pipeline, reset clears valid bits
    asv_pkg::ctl_t ctl_dly_reg [0:LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            for (int i = 0; i < LAT; i++)
            begin
                ctl_dly_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            ctl1_reg       <= ctl_in;
            ctl2_reg       <= ctl1_reg;
            ctl3_reg       <= ctl2_reg;
            ctl_dly_reg[0] <= ctl3_reg;
            for (int i = 1; i < LAT; i++)
            begin
                ctl_dly_reg[i] <= ctl_dly_reg[i-1];
            end
        end
    end

    // dividers
    logic [QW-1:0] q_loc, q_scl, q_skw, q_t3, q_t6, q_t7;

    asv_div u_div_loc (.clk(clk), .en(en), .num(n_loc_reg), .den(d_loc_reg), .quo(q_loc));
    asv_div u_div_scl (.clk(clk), .en(en), .num(n_scl_reg), .den(d_scl_reg), .quo(q_scl));
    asv_div u_div_skw (.clk(clk), .en(en), .num(n_skw_reg), .den(d_skw_reg), .quo(q_skw));
    asv_div u_div_t3  (.clk(clk), .en(en), .num(n_recip),   .den(d_t3_reg),  .quo(q_t3));
    asv_div u_div_t6  (.clk(clk), .en(en), .num(n_recip),   .den(d_t6_reg),  .quo(q_t6));
    asv_div u_div_t7  (.clk(clk), .en(en), .num(n_t7_reg),  .den(d_t7_reg),  .quo(q_t7));

    // output stage: round, combine, clamp
    asv_pkg::ctl_t      ctl_last;
    logic [QW-1:0]      t_loc, t_scl, t_skw, t_3, t_6, t_7;
    logic signed [38:0] loc_sum, scl_sum, skw_sum;
    logic [32:0]        loc_sat, scl_sat, skw_sat;

    assign ctl_last = ctl_dly_reg[LAT-1];
    assign t_loc    = round_term(q_loc);
    assign t_scl    = round_term(q_scl);
    assign t_skw    = round_term(q_skw);
    assign t_3      = round_term(q_t3);
    assign t_6      = round_term(q_t6);
    assign t_7      = round_term(q_t7);

    assign loc_sum = ctl_last.neg ? -39'(t_loc) : 39'(t_loc);
    assign scl_sum = 39'(t_scl) - 39'(t_3);
    assign skw_sum = 39'(t_6) - 39'(t_7) + (ctl_last.neg ? 39'(t_skw) : -39'(t_skw));

    assign loc_sat = clamp32(loc_sum);
    assign scl_sat = clamp32(scl_sum);
    assign skw_sat = clamp32(skw_sum);

    logic        out_vld_reg;
    logic [95:0] out_data_reg, out_data_next;
    logic [1:0]  out_user_reg, out_user_next;

    always_comb
    begin
        if (ctl_last.inv)
        begin
            out_data_next = '0;
            out_user_next = 2'b10;
        end
        else
        begin
            out_data_next = {skw_sat[31:0], scl_sat[31:0], loc_sat[31:0]};
            out_user_next = {1'b0, loc_sat[32] | scl_sat[32] | skw_sat[32]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= ctl_last.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    `ASV_ASSERT_NOW(a_inv_zero, m_axis_tvalid && m_axis_tuser[1], (m_axis_tdata == '0) && !m_axis_tuser[0], "invalid word carries nonzero scores")
    `ASV_ASSERT_NOW(a_sat_rail, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata[31:0] == 32'h7FFF_FFFF) || (m_axis_tdata[31:0] == 32'h8000_0000) || (m_axis_tdata[63:32] == 32'h7FFF_FFFF) || (m_axis_tdata[63:32] == 32'h8000_0000) || (m_axis_tdata[95:64] == 32'h7FFF_FFFF) || (m_axis_tdata[95:64] == 32'h8000_0000), "saturated word has no score at a rail")
    `ASV_ASSERT_NOW(a_stall_blocks, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken while output stalled")
    `ASV_ASSERT_NEXT(a_inv_capture, s_axis_tvalid && s_axis_tready && (s_axis_tdata[94:64] == '0), ctl1_reg.vld && ctl1_reg.inv, "zero scale not flagged in first stage")

endmodule

`default_nettype wire

### tb/sv/tb.sv
// self-checking bench for ald_score_vector_core: streams observations, predicts the three scores
`timescale 1ns / 1ps

module tb;

    localparam longint TERM_LIMIT = 64'sd1 << 60;

    typedef struct {
        logic [31:0] loc;
        logic [31:0] scl;
        logic [31:0] skw;
        logic        sat;
        logic        inv;
    } score_t;

    class score_ledger;
        score_t expected_scores[$];
        int     errors;
        int     n_words;
        int     n_invalid;
        int     n_sat;
        int     n_below;

        function new();
            errors = 0;
            n_words = 0;
            n_invalid = 0;
            n_sat = 0;
            n_below = 0;
        endfunction

        // round(a*b*c*2^sh / (d1*d2*2^rsh)), halves up, capped
        function automatic longint ratio_term(longint unsigned a, longint unsigned b,
                                              longint unsigned c, int sh,
                                              longint unsigned d1, longint unsigned d2,
                                              int rsh);
            logic [191:0]    x;
            longint unsigned v;
            x = a;
            x = x * b;
            x = x * c;
            x = x << (sh + 1);
            x = x / d1;
            x = x / d2;
            x = x >> rsh;
            if (x[191:64] != 0)
                return TERM_LIMIT;
            v = x[63:0];
            v = (v >> 1) + v[0];
            if (v > TERM_LIMIT)
                v = TERM_LIMIT;
            return longint'(v);
        endfunction

        function automatic logic [31:0] clip32(longint v, ref logic sat);
            if (v > 64'sd2147483647)
            begin
                v = 64'sd2147483647;
                sat = 1'b1;
            end
            if (v < -64'sd2147483648)
            begin
                v = -64'sd2147483648;
                sat = 1'b1;
            end
            return v[31:0];
        endfunction

        function void note_observation(logic signed [31:0] y, logic signed [31:0] th,
                                       logic [30:0] s, logic [30:0] k);
            score_t          e;
            longint          d;
            longint unsigned a;
            longint unsigned ss;
            longint unsigned sk;
            longint unsigned one2f;
            longint          loc;
            longint          scl;
            longint          skw;
            int              f;
            f = asv_pkg::FRAC_BITS;
            e.sat = 1'b0;
            e.inv = 1'b0;
            if (s == 0 || k == 0)
            begin
                e.loc = 0;
                e.scl = 0;
                e.skw = 0;
                e.inv = 1'b1;
                n_invalid++;
            end
            else
            begin
                d = longint'(y) - longint'(th);
                a = (d < 0) ? -d : d;
                ss = longint'(s) * longint'(s);
                sk = longint'(s) * longint'(k);
                one2f = 64'd1 << (2 * f);
                skw = ratio_term(1, 1, 1, 2 * f, k, 1, 0)
                    - ratio_term(2, k, 1, 2 * f, one2f + longint'(k) * longint'(k), 1, 0);
                scl = -ratio_term(1, 1, 1, 2 * f, s, 1, 0);
                if (d < 0)
                begin
                    n_below++;
                    loc = -ratio_term(asv_pkg::SQRT2_Q30, 1, 1, 3 * f, sk, 1,
                                      asv_pkg::SQRT2_FRAC);
                    scl += ratio_term(asv_pkg::SQRT2_Q30, a, 1, 3 * f, ss, k,
                                      asv_pkg::SQRT2_FRAC);
                    skw += ratio_term(asv_pkg::SQRT2_Q30, a, 1, 3 * f, sk, k,
                                      asv_pkg::SQRT2_FRAC);
                end
                else
                begin
                    loc = ratio_term(asv_pkg::SQRT2_Q30, k, 1, f, s, 1, asv_pkg::SQRT2_FRAC);
                    scl += ratio_term(asv_pkg::SQRT2_Q30, k, a, f, ss, 1, asv_pkg::SQRT2_FRAC);
                    skw -= ratio_term(asv_pkg::SQRT2_Q30, a, 1, f, s, 1, asv_pkg::SQRT2_FRAC);
                end
                e.loc = clip32(loc, e.sat);
                e.scl = clip32(scl, e.sat);
                e.skw = clip32(skw, e.sat);
                if (e.sat)
                    n_sat++;
            end
            n_words++;
            expected_scores.push_back(e);
        endfunction

        function void check_scores(logic [95:0] data, logic [1:0] user);
            score_t e;
            if (expected_scores.size() == 0)
            begin
                $display("%0t: output word with nothing expected: data %h user %b",
                         $time, data, user);
                errors++;
                return;
            end
            e = expected_scores.pop_front();
            if (data[31:0] !== e.loc)
            begin
                $display("%0t: score_location expected %h actual %h", $time, e.loc, data[31:0]);
                errors++;
            end
            if (data[63:32] !== e.scl)
            begin
                $display("%0t: score_scale expected %h actual %h", $time, e.scl, data[63:32]);
                errors++;
            end
            if (data[95:64] !== e.skw)
            begin
                $display("%0t: score_skew expected %h actual %h", $time, e.skw, data[95:64]);
                errors++;
            end
            if (user[0] !== e.sat)
            begin
                $display("%0t: saturated expected %b actual %b", $time, e.sat, user[0]);
                errors++;
            end
            if (user[1] !== e.inv)
            begin
                $display("%0t: invalid expected %b actual %b", $time, e.inv, user[1]);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    score_ledger ledger;
    bit          stim_done;
    bit          burst;
    int          n_cycles;

    ald_score_vector_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("timeout");
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_word(logic [31:0] y, logic [31:0] th, logic [30:0] s, logic [30:0] k);
        int g;
        s_axis_tdata <= {2'b00, k, s, th, y};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        g = gap_len();
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic send_random();
        int          r;
        logic [31:0] th;
        logic [31:0] y;
        logic [30:0] s;
        logic [30:0] k;
        r = $urandom_range(0, 99);
        if (r < 25)
        begin
            y = $urandom;
            th = $urandom;
            s = $urandom;
            k = $urandom;
        end
        else
        begin
            s = $urandom_range(2048, 1 << 21);
            k = $urandom_range(4096, 1 << 19);
            th = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
            y = th + ($signed($urandom_range(0, 1 << 22)) - (1 << 21));
            if (r < 30)
                y = th;
        end
        if (r >= 97)
            s = 0;
        else if (r >= 94)
            k = 0;
        send_word(y, th, s, k);
    endtask

    // sender
    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        rst_n = 1'b0;
        stim_done = 1'b0;
        burst = 1'b0;
        ledger = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_word(32'h7fffffff, 32'h80000000, 31'h7fffffff, 31'h7fffffff);
        send_word(32'h80000000, 32'h7fffffff, 31'h7fffffff, 31'h7fffffff);
        send_word(32'h80000000, 32'h7fffffff, 31'd1, 31'd1);
        send_word(32'h7fffffff, 32'h80000000, 31'd1, 31'd1);
        send_word(32'h00010000, 32'h00010000, 31'h10000, 31'h10000);
        send_word(32'h00000000, 32'h00000000, 31'd1, 31'h7fffffff);
        send_word(32'h00000000, 32'h00000000, 31'h7fffffff, 31'd1);
        send_word(32'h00020000, 32'h00010000, 31'h10000, 31'h10000);
        send_word(32'h00000000, 32'h00010000, 31'h10000, 31'h10000);
        send_word(32'hffff0000, 32'h00000000, 31'h8000, 31'h20000);
        send_word(32'h00030000, 32'h00000000, 31'h8000, 31'h20000);
        send_word(32'h00010000, 32'h00000000, 31'd0, 31'h10000);
        send_word(32'h00010000, 32'h00000000, 31'h10000, 31'd0);
        send_word(32'h7fffffff, 32'h80000000, 31'd0, 31'd0);
        send_word(32'h12345678, 32'h12345679, 31'h10000, 31'h10000);
        send_word(32'h12345679, 32'h12345678, 31'h10000, 31'h10000);
        send_word(32'h80000000, 32'h80000000, 31'h7fffffff, 31'd1);
        send_word(32'h00000001, 32'h00000000, 31'd1, 31'h7fffffff);
        for (int i = 0; i < 1250; i++)
        begin
            if (i % 64 == 0)
                burst = ($urandom_range(0, 3) == 0);
            send_random();
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver, with a long hold-off after reset to back the pipeline up, then random stalls
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        repeat (300) @(posedge clk);
        m_axis_tready <= 1'b0;
        repeat (200) @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(posedge clk);
            end
            else if ($urandom_range(0, 99) < 30)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            ledger.note_observation(s_axis_tdata[31:0], s_axis_tdata[63:32],
                                    s_axis_tdata[94:64], s_axis_tdata[125:95]);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            ledger.check_scores(m_axis_tdata, m_axis_tuser);
    end

    initial
    begin
        wait (stim_done);
        n_cycles = 0;
        while (ledger.expected_scores.size() != 0 && n_cycles < 100000)
        begin
            @(posedge clk);
            n_cycles++;
        end
        repeat (60) @(posedge clk);
        if (ledger.expected_scores.size() != 0)
        begin
            $display("%0d expected words never arrived", ledger.expected_scores.size());
            ledger.errors++;
        end
        $display("covered %0d words: %0d below location, %0d invalid, %0d clipped",
                 ledger.n_words, ledger.n_below, ledger.n_invalid, ledger.n_sat);
        if (ledger.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
